FILE: hw/rtl/lir_pkg.sv
`timescale 1ns / 1ps

package lir_pkg;

    localparam int NUM_CH      = 8;
    localparam int SAMPLE_W    = 16;
    localparam int CFG_CH_W    = 4;
    localparam int STEP_W      = 19;
    localparam int CH_IDX_W    = 3;
    localparam int CNT_W       = 3;
    localparam int RESULTS_MAX = 8;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [CFG_CH_W-1:0] CHANNELS_RESET = 4'd2;
    localparam logic [STEP_W-1:0]   STEP_RESET     = 19'd60211;

    // register index, taken from paddr[2]
    localparam logic REG_CHANNELS = 1'b0;
    localparam logic REG_STEP     = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_7;
        logic signed [SAMPLE_W-1:0] sample_6;
        logic signed [SAMPLE_W-1:0] sample_5;
        logic signed [SAMPLE_W-1:0] sample_4;
        logic signed [SAMPLE_W-1:0] sample_3;
        logic signed [SAMPLE_W-1:0] sample_2;
        logic signed [SAMPLE_W-1:0] sample_1;
        logic signed [SAMPLE_W-1:0] sample_0;
    } t_in_frame;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_sample_7;
        logic signed [SAMPLE_W-1:0] out_sample_6;
        logic signed [SAMPLE_W-1:0] out_sample_5;
        logic signed [SAMPLE_W-1:0] out_sample_4;
        logic signed [SAMPLE_W-1:0] out_sample_3;
        logic signed [SAMPLE_W-1:0] out_sample_2;
        logic signed [SAMPLE_W-1:0] out_sample_1;
        logic signed [SAMPLE_W-1:0] out_sample_0;
        logic                       last_of_run;
    } t_out_frame;

    typedef struct packed {
        logic                latch_in;
        logic                init_phase;
        logic                drop_frame;
        logic                shift_prev;
        logic                clear_work;
        logic                mul;
        logic                add;
        logic                emit;
        logic                last;
        logic [CH_IDX_W-1:0] ch;
    } t_dp_cmd;

    typedef struct packed {
        logic phase_ge_one;
        logic sum_ge_one;
        logic out_free;
    } t_dp_status;

endpackage

FILE: hw/rtl/lir_datapath.sv
`timescale 1ns / 1ps

module lir_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lir_pkg::t_dp_cmd            i_cmd,
    output lir_pkg::t_dp_status         o_status,
    input  logic [lir_pkg::STEP_W-1:0]  i_step,
    input  lir_pkg::t_in_frame          i_in_data,
    output lir_pkg::t_out_frame         o_out_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall
);
    import lir_pkg::*;

    localparam int PH_W   = ((FRAC_BITS + 1 > STEP_W) ? FRAC_BITS + 1 : STEP_W) + 1;
    localparam int PROD_W = FRAC_BITS + SAMPLE_W + 2;
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam logic [PH_W-1:0]          ONE_FRAME  = PH_W'(1) << FRAC_BITS;
    localparam logic signed [PROD_W-1:0] TRUNC_BIAS = PROD_W'((1 << FRAC_BITS) - 1);

    logic signed [SAMPLE_W-1:0] r_prev [NUM_CH];
    logic signed [SAMPLE_W-1:0] r_cur  [NUM_CH];
    logic signed [SAMPLE_W-1:0] r_work [NUM_CH];
    logic signed [SAMPLE_W-1:0] in_arr [NUM_CH];
    logic [PH_W-1:0]            r_phase;
    logic [PH_W-1:0]            phase_sum;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [PROD_W-1:0]   n_prod;
    logic signed [PROD_W-1:0]   biased;
    logic signed [SAMPLE_W-1:0] r_base;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [FRAC_BITS:0]  frac_s;
    logic signed [DIFF_W-1:0]   q;
    logic signed [DIFF_W:0]     lerp_sum;
    t_out_frame                 r_out;
    t_out_frame                 n_out;
    logic                       r_out_valid;

    assign in_arr[0] = i_in_data.sample_0;
    assign in_arr[1] = i_in_data.sample_1;
    assign in_arr[2] = i_in_data.sample_2;
    assign in_arr[3] = i_in_data.sample_3;
    assign in_arr[4] = i_in_data.sample_4;
    assign in_arr[5] = i_in_data.sample_5;
    assign in_arr[6] = i_in_data.sample_6;
    assign in_arr[7] = i_in_data.sample_7;

    assign phase_sum = r_phase + PH_W'(i_step);

    assign o_status.phase_ge_one = (r_phase >= ONE_FRAME);
    assign o_status.sum_ge_one   = (phase_sum >= ONE_FRAME);
    assign o_status.out_free     = !r_out_valid || !i_out_stall;

    // fraction times difference, truncated toward zero
    assign diff   = DIFF_W'(r_cur[i_cmd.ch]) - DIFF_W'(r_prev[i_cmd.ch]);
    assign frac_s = {1'b0, r_phase[FRAC_BITS-1:0]};
    assign n_prod = PROD_W'(frac_s) * PROD_W'(diff);

    assign biased   = r_prod + (r_prod[PROD_W-1] ? TRUNC_BIAS : PROD_W'(0));
    assign q        = biased[FRAC_BITS +: DIFF_W];
    assign lerp_sum = (DIFF_W + 1)'(r_base) + (DIFF_W + 1)'(q);

    always_comb begin
        n_out.out_sample_0 = r_work[0];
        n_out.out_sample_1 = r_work[1];
        n_out.out_sample_2 = r_work[2];
        n_out.out_sample_3 = r_work[3];
        n_out.out_sample_4 = r_work[4];
        n_out.out_sample_5 = r_work[5];
        n_out.out_sample_6 = r_work[6];
        n_out.out_sample_7 = r_work[7];
        n_out.last_of_run  = i_cmd.last;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_cur[i] <= in_arr[i];
            end
        end
        if (i_cmd.shift_prev) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_prev[i] <= r_cur[i];
            end
        end
        if (i_cmd.clear_work) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_work[i] <= '0;
            end
        end else if (i_cmd.add) begin
            r_work[i_cmd.ch] <= lerp_sum[SAMPLE_W-1:0];
        end
        if (i_cmd.mul) begin
            r_prod <= n_prod;
            r_base <= r_prev[i_cmd.ch];
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.init_phase) begin
                r_phase <= '0;
            end else if (i_cmd.drop_frame) begin
                r_phase <= r_phase - ONE_FRAME;
            end else if (i_cmd.emit) begin
                if (!i_cmd.last) begin
                    r_phase <= phase_sum;
                end else if (phase_sum >= ONE_FRAME) begin
                    r_phase <= phase_sum - ONE_FRAME;
                end else begin
                    r_phase <= '0;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_data  = r_out;
    assign o_out_valid = r_out_valid;

endmodule

FILE: hw/rtl/lir_ctrl.sv
`timescale 1ns / 1ps

module lir_ctrl #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lir_pkg::CFG_CH_W-1:0]  i_channels,
    input  lir_pkg::t_dp_status           i_status,
    output lir_pkg::t_dp_cmd              o_cmd
);
    import lir_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_ADD,
        S_EMIT
    } t_state;

    t_state              r_state, n_state;
    logic [CH_IDX_W-1:0] r_ch, n_ch;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_primed, n_primed;
    logic [CFG_CH_W-1:0] nch;
    logic [CH_IDX_W-1:0] last_ch;
    logic                last_frame;

    always_comb begin
        if (i_channels == '0) begin
            nch = CFG_CH_W'(1);
        end else if (i_channels > CFG_CH_W'(MAX_CHANNELS)) begin
            nch = CFG_CH_W'(MAX_CHANNELS);
        end else begin
            nch = i_channels;
        end
    end

    assign last_ch    = CH_IDX_W'(nch - CFG_CH_W'(1));
    assign last_frame = i_status.sum_ge_one || (r_cnt == CNT_W'(RESULTS_MAX - 1));

    always_comb begin
        n_state  = r_state;
        n_ch     = r_ch;
        n_cnt    = r_cnt;
        n_primed = r_primed;
        o_cmd    = '0;
        o_cmd.ch = r_ch;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!r_primed) begin
                    o_cmd.shift_prev = 1'b1;
                    o_cmd.init_phase = 1'b1;
                    n_primed         = 1'b1;
                    n_state          = S_IDLE;
                end else if (i_status.phase_ge_one) begin
                    o_cmd.shift_prev = 1'b1;
                    o_cmd.drop_frame = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.clear_work = 1'b1;
                    n_ch             = '0;
                    n_cnt            = '0;
                    n_state          = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                if (r_ch == last_ch) begin
                    n_state = S_EMIT;
                end else begin
                    n_ch    = r_ch + CH_IDX_W'(1);
                    n_state = S_MUL;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = last_frame;
                    if (last_frame) begin
                        o_cmd.shift_prev = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        n_cnt   = r_cnt + CNT_W'(1);
                        n_ch    = '0;
                        n_state = S_MUL;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ch     <= '0;
            r_cnt    <= '0;
            r_primed <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ch     <= n_ch;
            r_cnt    <= n_cnt;
            r_primed <= n_primed;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

FILE: hw/rtl/linear_interp_resampler.sv
`timescale 1ns / 1ps
// Flow per input: the transfer is latched in the idle state and checked; then, for each output frame,
// one shared multiplier and adder work the active channels one at a time (a multiply state,
// then an add state), and the emit state registers the frame. An input gives up to 8 output
// frames (or none); the input side stalls until done, also while the output side stalls.
// Reset is synchronous: channels = 2, step = 60211, phase = 0, no frame seen, output empty.

module linear_interp_resampler #(
    parameter int MAX_CHANNELS = 8,
    parameter int FRAC_BITS    = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  lir_pkg::t_in_frame              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output lir_pkg::t_out_frame             o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lir_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lir_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lir_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import lir_pkg::*;

    logic [CFG_CH_W-1:0] r_channels;
    logic [STEP_W-1:0]   r_step;
    logic                cfg_wr;
    t_dp_cmd             dp_cmd;
    t_dp_status          dp_status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channels <= CHANNELS_RESET;
            r_step     <= STEP_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_CHANNELS: r_channels <= pwdata[CFG_CH_W-1:0];
                REG_STEP:     r_step     <= pwdata[STEP_W-1:0];
                default:      r_step     <= r_step;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_CHANNELS: prdata = APB_DATA_W'(r_channels);
            REG_STEP:     prdata = APB_DATA_W'(r_step);
            default:      prdata = '0;
        endcase
    end

    lir_ctrl #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_channels (r_channels),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    lir_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_step      (r_step),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall)
    );

endmodule

FILE: hw/rtl/lir_checker.sv
`timescale 1ns / 1ps

module lir_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input lir_pkg::t_out_frame o_out_data
);

    // output register empties on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // one frame at a time: input side closes right after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second input taken while busy");

    // no output frame can appear in the cycle right after an input transfer
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("output appeared too early");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output changed");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
